// ===== rtl/lpcp_pkg.sv =====
// Shared constants, types and a helper function for the lidar point projection block.
// Depends on nothing; every other file refers to it by scoped names.
package lpcp_pkg;

    // Input and coefficient widths.
    localparam int COORD_W   = 18;
    localparam int FRAC_BITS = 14;
    localparam int COEF_W    = 16;

    // Extrinsic transform datapath.
    localparam int PROD_W  = COORD_W + COEF_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int SHIFT_W = SUM_W - FRAC_BITS;
    localparam int CAM_W   = ((SHIFT_W > COEF_W) ? SHIFT_W : COEF_W) + 1;
    localparam longint CAM_LIMIT = 64'sd1073741824;

    // Projection divider: quotient bits kept before the result counts as saturated.
    localparam int QBITS = 18;
    localparam int Q_W   = QBITS + 1;
    localparam int FP_W  = COEF_W + 1 + CAM_W;
    localparam int NUM_W = FP_W + 1;
    localparam int DIV_W = CAM_W + 4 + QBITS;

    // Distance and color datapath.
    localparam int SQ_W  = 2 * CAM_W;
    localparam int SQX_W = SQ_W + 1;
    localparam int COL_W = CAM_W + 8;
    localparam int LVL_W = 8;

    // Stage counts of the units and of the whole pipeline.
    localparam int TR_LAT    = 4;
    localparam int DIV_LAT   = QBITS + 3;
    localparam int SQ_LAT    = CAM_W + 2;
    localparam int COL_LAT   = LVL_W + 3;
    localparam int PIX_END   = TR_LAT + DIV_LAT + 1;
    localparam int COL_END   = TR_LAT + SQ_LAT + COL_LAT;
    localparam int TOTAL_LAT = (PIX_END > COL_END) ? PIX_END : COL_END;
    localparam int SIDE_DLY  = TOTAL_LAT - TR_LAT;
    localparam int PIX_DLY   = TOTAL_LAT - TR_LAT - DIV_LAT;
    localparam int COL_DLY   = TOTAL_LAT - COL_END;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [CAM_W-1:0]   cam_t;
    typedef logic        [CAM_W-1:0]   dist_t;
    typedef logic signed [Q_W-1:0]     quot_t;
    typedef logic signed [15:0]        pixel_t;
    typedef logic        [LVL_W-1:0]   level_t;

    typedef enum logic [2:0] {
        REG_EXT_X = 3'd0,
        REG_EXT_Y = 3'd1,
        REG_EXT_Z = 3'd2,
        REG_INTR  = 3'd3,
        REG_SIZE  = 3'd4,
        REG_SIDE  = 3'd5,
        REG_RANGE = 3'd6,
        REG_ROI   = 3'd7
    } reg_idx_t;

    typedef enum logic [2:0] {
        SIDE_NONE = 3'd0,
        SIDE_XPOS = 3'd1,
        SIDE_XNEG = 3'd2,
        SIDE_YPOS = 3'd3,
        SIDE_YNEG = 3'd4
    } side_mode_t;

    typedef struct packed {
        logic reject;
        logic dinv;
    } side_t;

    typedef struct packed {
        pixel_t u;
        pixel_t v;
        logic   in_image;
        logic   in_roi;
    } pix_t;

    typedef struct packed {
        logic   filtered_out;
        logic   depth_invalid;
        pixel_t pixel_u;
        pixel_t pixel_v;
        logic   in_image;
        logic   in_roi;
        level_t red_level;
        level_t green_level;
    } result_t;

    // Clamp a camera-frame coordinate to +-2^30.
    function automatic cam_t sat_cam(input cam_t v);
        longint w;
        w = longint'(v);
        if (w > CAM_LIMIT - 1)
            w = CAM_LIMIT - 1;
        else if (w < -CAM_LIMIT)
            w = -CAM_LIMIT;
        return cam_t'(w);
    endfunction

endpackage

// ===== rtl/lpcp_if.sv =====
// Valid/ready channel interfaces for lidar points and projection results.
// Depends on lpcp_pkg for the payload types.
interface lpcp_point_if;
    logic               valid;
    logic               ready;
    lpcp_pkg::coord_t   point_x;
    lpcp_pkg::coord_t   point_y;
    lpcp_pkg::coord_t   point_z;

    modport source (output valid, output point_x, output point_y, output point_z,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input point_z,
                    output ready);
endinterface

interface lpcp_result_if;
    logic               valid;
    logic               ready;
    logic               filtered_out;
    logic               depth_invalid;
    lpcp_pkg::pixel_t   pixel_u;
    lpcp_pkg::pixel_t   pixel_v;
    logic               in_image;
    logic               in_roi;
    lpcp_pkg::level_t   red_level;
    lpcp_pkg::level_t   green_level;

    modport source (output valid, output filtered_out, output depth_invalid,
                    output pixel_u, output pixel_v, output in_image, output in_roi,
                    output red_level, output green_level, input ready);
    modport sink   (input valid, input filtered_out, input depth_invalid,
                    input pixel_u, input pixel_v, input in_image, input in_roi,
                    input red_level, input green_level, output ready);
endinterface

// ===== rtl/lpcp_transform.sv =====
// Side filter and 3x4 extrinsic transform into the camera frame, four stages.
// Depends on lpcp_pkg.
module lpcp_transform (
    input  logic              clk,
    input  logic              en,
    input  lpcp_pkg::coord_t  px,
    input  lpcp_pkg::coord_t  py,
    input  lpcp_pkg::coord_t  pz,
    input  logic [63:0]       ext_row [3],
    input  logic [2:0]        side,
    output logic              reject,
    output lpcp_pkg::cam_t    cam [3]
);

    lpcp_pkg::coord_t                         p_reg [3];
    logic signed [lpcp_pkg::PROD_W-1:0]       prod_reg [3][3];
    logic signed [lpcp_pkg::SUM_W-1:0]        acc_reg [3];
    lpcp_pkg::cam_t                           cam_reg [3];
    logic [3:0]                               rej_reg;
    logic                                     rej_in;

    always_comb
    begin
        rej_in = 1'b0;
        unique case (lpcp_pkg::side_mode_t'(side))
            lpcp_pkg::SIDE_XPOS: rej_in = (px <= 0);
            lpcp_pkg::SIDE_XNEG: rej_in = (px >= 0);
            lpcp_pkg::SIDE_YPOS: rej_in = (py <= 0);
            lpcp_pkg::SIDE_YNEG: rej_in = (py >= 0);
            default:             rej_in = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0] <= px;
            p_reg[1] <= py;
            p_reg[2] <= pz;
            rej_reg  <= {rej_reg[2:0], rej_in};
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    prod_reg[i][j] <= $signed(ext_row[i][lpcp_pkg::COEF_W*j +: lpcp_pkg::COEF_W])
                                      * p_reg[j];
                end
                acc_reg[i] <= lpcp_pkg::SUM_W'(prod_reg[i][0])
                            + lpcp_pkg::SUM_W'(prod_reg[i][1])
                            + lpcp_pkg::SUM_W'(prod_reg[i][2]);
                // Arithmetic shift gives the floor of the fixed-point product sum.
                cam_reg[i] <= lpcp_pkg::sat_cam(
                    lpcp_pkg::CAM_W'(acc_reg[i] >>> lpcp_pkg::FRAC_BITS)
                    + lpcp_pkg::CAM_W'($signed(ext_row[i][63:48])));
            end
        end
    end

    assign reject = rej_reg[3];
    assign cam    = cam_reg;

endmodule

// ===== rtl/lpcp_div.sv =====
// Pipelined pinhole projection quotient trunc((f*num + c*den) / (16*den)), one bit per stage.
// Depends on lpcp_pkg.
module lpcp_div (
    input  logic              clk,
    input  logic              en,
    input  logic [15:0]       f,
    input  logic [15:0]       ctr,
    input  lpcp_pkg::cam_t    num_c,
    input  lpcp_pkg::cam_t    den_c,
    output lpcp_pkg::quot_t   quot
);

    localparam int QB = lpcp_pkg::QBITS;

    logic signed [lpcp_pkg::FP_W-1:0]  pf_reg;
    logic signed [lpcp_pkg::FP_W-1:0]  pc_reg;
    lpcp_pkg::cam_t                    den_reg;
    logic [lpcp_pkg::DIV_W-1:0]        rem_reg [QB+1];
    logic [lpcp_pkg::CAM_W+3:0]        dv_reg  [QB+1];
    logic [QB-1:0]                     q_reg   [QB+1];
    logic                              neg_reg [QB+1];
    lpcp_pkg::quot_t                   quot_reg;

    logic signed [lpcp_pkg::NUM_W-1:0] n;
    logic [lpcp_pkg::NUM_W-1:0]        nbits;
    logic [lpcp_pkg::NUM_W-1:0]        nmag;
    logic [lpcp_pkg::CAM_W-1:0]        dbits;
    logic [lpcp_pkg::CAM_W-1:0]        dmag;
    logic [lpcp_pkg::DIV_W-1:0]        trial [QB];
    logic                              take  [QB];
    lpcp_pkg::quot_t                   mag;

    always_comb
    begin
        n     = lpcp_pkg::NUM_W'(pf_reg) + lpcp_pkg::NUM_W'(pc_reg);
        nbits = n;
        nmag  = n[lpcp_pkg::NUM_W-1] ? (~nbits + 1'b1) : nbits;
        dbits = den_reg;
        dmag  = den_reg[lpcp_pkg::CAM_W-1] ? (~dbits + 1'b1) : dbits;
        for (int k = 0; k < QB; k++)
        begin
            trial[k] = lpcp_pkg::DIV_W'(dv_reg[k]) << (QB - 1 - k);
            take[k]  = (rem_reg[k] >= trial[k]);
        end
        // A set top bit means the magnitude is at least 2^(QB-1): clamp it there.
        mag = q_reg[QB][QB-1] ? (lpcp_pkg::Q_W'(1) << (QB - 1))
                              : lpcp_pkg::quot_t'(lpcp_pkg::Q_W'(q_reg[QB]));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pf_reg     <= $signed({1'b0, f}) * num_c;
            pc_reg     <= $signed({1'b0, ctr}) * den_c;
            den_reg    <= den_c;
            rem_reg[0] <= lpcp_pkg::DIV_W'(nmag);
            dv_reg[0]  <= {dmag, 4'b0000};
            q_reg[0]   <= '0;
            neg_reg[0] <= n[lpcp_pkg::NUM_W-1] ^ den_reg[lpcp_pkg::CAM_W-1];
            for (int k = 0; k < QB; k++)
            begin
                rem_reg[k+1] <= take[k] ? (rem_reg[k] - trial[k]) : rem_reg[k];
                q_reg[k+1]   <= q_reg[k] | (take[k] ? (QB'(1) << (QB - 1 - k)) : '0);
                dv_reg[k+1]  <= dv_reg[k];
                neg_reg[k+1] <= neg_reg[k];
            end
            quot_reg <= neg_reg[QB] ? -mag : mag;
        end
    end

    assign quot = quot_reg;

endmodule

// ===== rtl/lpcp_sqrt.sv =====
// Camera-frame distance: sum of squares, then a restoring square root, one root bit per stage.
// Depends on lpcp_pkg.
module lpcp_sqrt (
    input  logic              clk,
    input  logic              en,
    input  lpcp_pkg::cam_t    cam [3],
    output lpcp_pkg::dist_t   distance
);

    localparam int RB = lpcp_pkg::CAM_W;

    logic [lpcp_pkg::SQ_W-1:0]         sq_reg   [3];
    logic [lpcp_pkg::SQ_W-1:0]         rem_reg  [RB+1];
    lpcp_pkg::dist_t                   root_reg [RB+1];

    logic signed [lpcp_pkg::SQ_W-1:0]  sqs   [3];
    logic [lpcp_pkg::SQX_W-1:0]        trial [RB];
    logic                              take  [RB];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            sqs[i] = cam[i] * cam[i];
        // Adding root bit b raises root^2 by (root << (b+1)) + 2^(2b).
        for (int k = 0; k < RB; k++)
        begin
            trial[k] = (lpcp_pkg::SQX_W'(root_reg[k]) << (RB - k))
                     + (lpcp_pkg::SQX_W'(1) << (2 * (RB - 1 - k)));
            take[k]  = (lpcp_pkg::SQX_W'(rem_reg[k]) >= trial[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                sq_reg[i] <= sqs[i];
            rem_reg[0]  <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            root_reg[0] <= '0;
            for (int k = 0; k < RB; k++)
            begin
                rem_reg[k+1]  <= take[k]
                    ? lpcp_pkg::SQ_W'(lpcp_pkg::SQX_W'(rem_reg[k]) - trial[k])
                    : rem_reg[k];
                root_reg[k+1] <= root_reg[k]
                    | (take[k] ? (lpcp_pkg::dist_t'(1) << (RB - 1 - k)) : '0);
            end
        end
    end

    assign distance = root_reg[RB];

endmodule

// ===== rtl/lpcp_color.sv =====
// Red and green levels from distance versus the color range, two 8-bit dividers in lockstep.
// Depends on lpcp_pkg.
module lpcp_color (
    input  logic              clk,
    input  logic              en,
    input  lpcp_pkg::dist_t   distance,
    input  logic [15:0]       range,
    output lpcp_pkg::level_t  red,
    output lpcp_pkg::level_t  green
);

    localparam int LB = lpcp_pkg::LVL_W;

    lpcp_pkg::dist_t              diff_reg;
    logic [15:0]                  r_reg;
    logic [lpcp_pkg::COL_W-1:0]   remr_reg [LB+1];
    logic [lpcp_pkg::COL_W-1:0]   remg_reg [LB+1];
    logic [15:0]                  rd_reg   [LB+1];
    logic                         big_reg  [LB+1];
    lpcp_pkg::level_t             qr_reg   [LB+1];
    lpcp_pkg::level_t             qg_reg   [LB+1];
    lpcp_pkg::level_t             red_reg;
    lpcp_pkg::level_t             green_reg;

    logic [15:0]                  r1;
    lpcp_pkg::dist_t              rx;
    lpcp_pkg::dist_t              diff;
    lpcp_pkg::dist_t              rx2;
    lpcp_pkg::dist_t              gap;
    logic [lpcp_pkg::COL_W-1:0]   d_ext;
    logic [lpcp_pkg::COL_W-1:0]   g_ext;
    logic [lpcp_pkg::COL_W-1:0]   nr;
    logic [lpcp_pkg::COL_W-1:0]   ng;
    logic                         big;
    logic [lpcp_pkg::COL_W-1:0]   trial [LB];
    logic                         taker [LB];
    logic                         takeg [LB];

    always_comb
    begin
        r1    = (range == 16'd0) ? 16'd1 : range;
        rx    = lpcp_pkg::dist_t'(r1);
        diff  = (distance > rx) ? (distance - rx) : (rx - distance);
        rx2   = lpcp_pkg::dist_t'(r_reg);
        gap   = rx2 - diff_reg;
        d_ext = lpcp_pkg::COL_W'(diff_reg);
        g_ext = lpcp_pkg::COL_W'(gap);
        nr    = (d_ext << 8) - d_ext;
        big   = (nr >= (lpcp_pkg::COL_W'(r_reg) << 8));
        ng    = (diff_reg >= rx2) ? '0 : ((g_ext << 8) - g_ext);
        for (int k = 0; k < LB; k++)
        begin
            trial[k] = lpcp_pkg::COL_W'(rd_reg[k]) << (LB - 1 - k);
            taker[k] = (remr_reg[k] >= trial[k]);
            takeg[k] = (remg_reg[k] >= trial[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diff_reg    <= diff;
            r_reg       <= r1;
            remr_reg[0] <= nr;
            remg_reg[0] <= ng;
            rd_reg[0]   <= r_reg;
            big_reg[0]  <= big;
            qr_reg[0]   <= '0;
            qg_reg[0]   <= '0;
            for (int k = 0; k < LB; k++)
            begin
                remr_reg[k+1] <= taker[k] ? (remr_reg[k] - trial[k]) : remr_reg[k];
                remg_reg[k+1] <= takeg[k] ? (remg_reg[k] - trial[k]) : remg_reg[k];
                qr_reg[k+1]   <= qr_reg[k] | (taker[k] ? (LB'(1) << (LB - 1 - k)) : '0);
                qg_reg[k+1]   <= qg_reg[k] | (takeg[k] ? (LB'(1) << (LB - 1 - k)) : '0);
                rd_reg[k+1]   <= rd_reg[k];
                big_reg[k+1]  <= big_reg[k];
            end
            red_reg   <= big_reg[LB] ? '1 : qr_reg[LB];
            green_reg <= qg_reg[LB];
        end
    end

    assign red   = red_reg;
    assign green = green_reg;

endmodule

// ===== rtl/lidar_point_camera_projection.sv =====
// Top level of the lidar point to camera pixel projection pipeline.
// Depends on lpcp_pkg, lpcp_if, lpcp_transform, lpcp_div, lpcp_sqrt and lpcp_color.
//
// Points arrive on the point channel (valid/ready) and one result per point leaves
// on the result channel in the same order. A transaction happens on a rising edge
// with valid and ready both high. Configuration is a plain write port: cfg_wr_en,
// cfg_index and cfg_data, written while no point is in flight.
// The datapath is a 40-stage pipeline with default widths: four transform stages,
// one-bit-per-stage projection dividers, a 25-stage square root for the distance and
// an 11-stage color divider. Each result passes through the output register after the
// last stage, and one point can be accepted every cycle while the skid register is empty.
// The output register is backed by a one-entry skid register. When the receiver
// stalls, the pipeline moves one more transaction into the skid register and then
// holds every stage; nothing is dropped or repeated. Ready is a register output.
// Reset clears the pipeline valid bits, the output and skid valid flags, and loads
// the configuration defaults (identity rotation, color range 2560).
module lidar_point_camera_projection (
    input  logic                  clk,
    input  logic                  rst_n,
    lpcp_point_if.sink            point,
    lpcp_result_if.source         result,
    input  logic                  cfg_wr_en,
    input  logic [2:0]            cfg_index,
    input  logic [63:0]           cfg_data
);

    // Configuration registers.
    logic [63:0]  ext_row_reg [3];
    logic [63:0]  intr_reg;
    logic [31:0]  size_reg;
    logic [2:0]   side_reg;
    logic [15:0]  crange_reg;
    logic [63:0]  roi_reg;

    logic [lpcp_pkg::TOTAL_LAT-1:0] vld_reg;
    lpcp_pkg::side_t   side_dly_reg [lpcp_pkg::SIDE_DLY];
    lpcp_pkg::pix_t    pix_dly_reg  [lpcp_pkg::PIX_DLY];

    logic              out_vld_reg, out_vld_next;
    lpcp_pkg::result_t out_data_reg, out_data_next;
    logic              skid_vld_reg, skid_vld_next;
    lpcp_pkg::result_t skid_data_reg, skid_data_next;

    logic              adv;
    logic              pipe_fire;
    logic              tr_reject;
    lpcp_pkg::cam_t    cam [3];
    lpcp_pkg::quot_t   qu, qv;
    lpcp_pkg::dist_t   distance;
    lpcp_pkg::level_t  col_red, col_green;
    lpcp_pkg::level_t  red_fin, green_fin;
    lpcp_pkg::side_t   side_now;
    lpcp_pkg::pix_t    pix_now;
    lpcp_pkg::result_t pipe_res;
    lpcp_pkg::quot_t   w_q, h_q, umin_q, umax_q, vmin_q, vmax_q;

    function automatic lpcp_pkg::pixel_t sat16(input lpcp_pkg::quot_t q);
        if (q > 32767)
            return 16'sh7FFF;
        else if (q < -32768)
            return 16'sh8000;
        else
            return lpcp_pkg::pixel_t'(q);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_row_reg[0] <= 64'd16384;
            ext_row_reg[1] <= 64'd16384 << 16;
            ext_row_reg[2] <= 64'd16384 << 32;
            intr_reg       <= '0;
            size_reg       <= '0;
            side_reg       <= '0;
            crange_reg     <= 16'd2560;
            roi_reg        <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (lpcp_pkg::reg_idx_t'(cfg_index))
                lpcp_pkg::REG_EXT_X: ext_row_reg[0] <= cfg_data;
                lpcp_pkg::REG_EXT_Y: ext_row_reg[1] <= cfg_data;
                lpcp_pkg::REG_EXT_Z: ext_row_reg[2] <= cfg_data;
                lpcp_pkg::REG_INTR:  intr_reg       <= cfg_data;
                lpcp_pkg::REG_SIZE:  size_reg       <= cfg_data[31:0];
                lpcp_pkg::REG_SIDE:  side_reg       <= cfg_data[2:0];
                lpcp_pkg::REG_RANGE: crange_reg     <= cfg_data[15:0];
                lpcp_pkg::REG_ROI:   roi_reg        <= cfg_data;
            endcase
        end
    end

    // Every stage moves together; only a full skid register holds them.
    assign adv         = !skid_vld_reg;
    assign point.ready = adv;
    assign pipe_fire   = vld_reg[lpcp_pkg::TOTAL_LAT-1] && adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[lpcp_pkg::TOTAL_LAT-2:0], point.valid};
    end

    lpcp_transform u_transform (
        .clk     (clk),
        .en      (adv),
        .px      (point.point_x),
        .py      (point.point_y),
        .pz      (point.point_z),
        .ext_row (ext_row_reg),
        .side    (side_reg),
        .reject  (tr_reject),
        .cam     (cam)
    );

    lpcp_div u_div_u (
        .clk   (clk),
        .en    (adv),
        .f     (intr_reg[15:0]),
        .ctr   (intr_reg[47:32]),
        .num_c (cam[0]),
        .den_c (cam[2]),
        .quot  (qu)
    );

    lpcp_div u_div_v (
        .clk   (clk),
        .en    (adv),
        .f     (intr_reg[31:16]),
        .ctr   (intr_reg[63:48]),
        .num_c (cam[1]),
        .den_c (cam[2]),
        .quot  (qv)
    );

    lpcp_sqrt u_sqrt (
        .clk      (clk),
        .en       (adv),
        .cam      (cam),
        .distance (distance)
    );

    lpcp_color u_color (
        .clk      (clk),
        .en       (adv),
        .distance (distance),
        .range    (crange_reg),
        .red      (col_red),
        .green    (col_green)
    );

    // Bounds widened to the signed quotient width so the compares stay signed.
    assign w_q    = lpcp_pkg::quot_t'(size_reg[15:0]);
    assign h_q    = lpcp_pkg::quot_t'(size_reg[31:16]);
    assign umin_q = lpcp_pkg::quot_t'(roi_reg[15:0]);
    assign umax_q = lpcp_pkg::quot_t'(roi_reg[31:16]);
    assign vmin_q = lpcp_pkg::quot_t'(roi_reg[47:32]);
    assign vmax_q = lpcp_pkg::quot_t'(roi_reg[63:48]);

    always_comb
    begin
        side_now.reject   = tr_reject;
        side_now.dinv     = (cam[2] == '0);
        pix_now.u         = sat16(qu);
        pix_now.v         = sat16(qv);
        pix_now.in_image  = (qu > 0) && (qu < w_q) && (qv > 0) && (qv < h_q);
        pix_now.in_roi    = (qu > umin_q) && (qu < umax_q) && (qv > vmin_q) && (qv < vmax_q);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_dly_reg[0] <= side_now;
            for (int i = 1; i < lpcp_pkg::SIDE_DLY; i++)
                side_dly_reg[i] <= side_dly_reg[i-1];
            pix_dly_reg[0] <= pix_now;
            for (int i = 1; i < lpcp_pkg::PIX_DLY; i++)
                pix_dly_reg[i] <= pix_dly_reg[i-1];
        end
    end

    if (lpcp_pkg::COL_DLY > 0)
    begin : g_col_dly
        lpcp_pkg::level_t red_dly_reg   [lpcp_pkg::COL_DLY];
        lpcp_pkg::level_t green_dly_reg [lpcp_pkg::COL_DLY];

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                red_dly_reg[0]   <= col_red;
                green_dly_reg[0] <= col_green;
                for (int i = 1; i < lpcp_pkg::COL_DLY; i++)
                begin
                    red_dly_reg[i]   <= red_dly_reg[i-1];
                    green_dly_reg[i] <= green_dly_reg[i-1];
                end
            end
        end

        assign red_fin   = red_dly_reg[lpcp_pkg::COL_DLY-1];
        assign green_fin = green_dly_reg[lpcp_pkg::COL_DLY-1];
    end
    else
    begin : g_col_now
        assign red_fin   = col_red;
        assign green_fin = col_green;
    end

    always_comb
    begin
        pipe_res = '0;
        if (side_dly_reg[lpcp_pkg::SIDE_DLY-1].reject)
            pipe_res.filtered_out = 1'b1;
        else if (side_dly_reg[lpcp_pkg::SIDE_DLY-1].dinv)
            pipe_res.depth_invalid = 1'b1;
        else
        begin
            pipe_res.pixel_u  = pix_dly_reg[lpcp_pkg::PIX_DLY-1].u;
            pipe_res.pixel_v  = pix_dly_reg[lpcp_pkg::PIX_DLY-1].v;
            pipe_res.in_image = pix_dly_reg[lpcp_pkg::PIX_DLY-1].in_image;
            pipe_res.in_roi   = pix_dly_reg[lpcp_pkg::PIX_DLY-1].in_roi;
            if (pix_dly_reg[lpcp_pkg::PIX_DLY-1].in_image)
            begin
                pipe_res.red_level   = red_fin;
                pipe_res.green_level = green_fin;
            end
        end
    end

    // Output register with a one-entry skid register behind it.
    always_comb
    begin
        out_vld_next   = out_vld_reg;
        out_data_next  = out_data_reg;
        skid_vld_next  = skid_vld_reg;
        skid_data_next = skid_data_reg;
        if (!out_vld_reg || result.ready)
        begin
            if (skid_vld_reg)
            begin
                out_vld_next  = 1'b1;
                out_data_next = skid_data_reg;
                skid_vld_next = 1'b0;
            end
            else
            begin
                out_vld_next  = pipe_fire;
                out_data_next = pipe_res;
            end
        end
        else if (pipe_fire)
        begin
            skid_vld_next  = 1'b1;
            skid_data_next = pipe_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign result.valid         = out_vld_reg;
    assign result.filtered_out  = out_data_reg.filtered_out;
    assign result.depth_invalid = out_data_reg.depth_invalid;
    assign result.pixel_u       = out_data_reg.pixel_u;
    assign result.pixel_v       = out_data_reg.pixel_v;
    assign result.in_image      = out_data_reg.in_image;
    assign result.in_roi        = out_data_reg.in_roi;
    assign result.red_level     = out_data_reg.red_level;
    assign result.green_level   = out_data_reg.green_level;

endmodule
